/* rtl/core/tfcm_pkg.sv */
// package for the thermal false-color mapper: shared types and constants
// no dependencies; imported by every module under rtl/core
package tfcm_pkg;

    // default image geometry
    localparam int DEF_WIDTH  = 80;
    localparam int DEF_HEIGHT = 60;

    // field widths
    localparam int LINE_W  = 6;
    localparam int COL_W   = 7;
    localparam int PIX_W   = 16;
    localparam int IDX_W   = 13;
    localparam int LEVEL_W = 11;
    localparam int CHAN_W  = 8;

    // mapping constants
    localparam logic [3:0] DISCARD_NIBBLE = 4'hF;
    localparam int STAT_MIN_START = 65536;
    localparam int FIXED_BASE     = 4096;
    localparam int MEAN_BIAS      = 128;
    localparam int GREY_MAX       = 255;
    localparam int COLOUR_SPAN    = 1280;
    localparam int COLOUR_MAX     = 1279;

    // request queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // divider: reciprocal multiply, product, correction and result cycles
    localparam int DIV_CNT_W = 3;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_COLOUR = 2'd1;
    localparam logic [1:0] REG_FIXED  = 2'd2;
    localparam logic [1:0] REG_ALPHA  = 2'd3;

    // color ramp bands, selected by level bits 10:8
    localparam logic [2:0] BAND_BLUE   = 3'd0;
    localparam logic [2:0] BAND_CYAN   = 3'd1;
    localparam logic [2:0] BAND_GREEN  = 3'd2;
    localparam logic [2:0] BAND_YELLOW = 3'd3;

    typedef enum logic [1:0] {
        MODE_MEAN = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_MAX  = 2'd2,
        MODE_RAW  = 2'd3
    } ref_mode_t;

    // one classified request waiting for the back end
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   col;
    } entry_t;

    // settings the back end needs
    typedef struct packed {
        logic              colour;
        logic [CHAN_W-1:0] alpha;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/core/tfcm_div.sv */
// signed divider by the constant pixel count, truncating toward zero
// depends on tfcm_pkg; reciprocal multiply with one correction step
module tfcm_div #(
    parameter int DIVISOR = tfcm_pkg::DEF_WIDTH * tfcm_pkg::DEF_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tfcm_pkg::div_req_t  req,
    output tfcm_pkg::div_rsp_t  rsp
);
    import tfcm_pkg::*;

    localparam int              DivW   = $clog2(DIVISOR + 1);
    localparam logic [DivW-1:0] DivK   = DivW'(DIVISOR);
    localparam longint          MagicL = (longint'(1) << 31) / longint'(DIVISOR);
    localparam logic [31:0]     Magic  = 32'(MagicL);

    localparam logic [DIV_CNT_W-1:0] StepMul = DIV_STEPS;
    localparam logic [DIV_CNT_W-1:0] StepEst = DIV_STEPS - DIV_CNT_W'(1);
    localparam logic [DIV_CNT_W-1:0] StepFix = DIV_STEPS - DIV_CNT_W'(2);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [31:0]          num_reg;
    logic [31:0]          quo_reg;
    logic [31:0]          qd_reg;
    logic                 neg_reg;

    logic [63:0] prod_next;
    logic [31:0] qd_next;
    logic [31:0] rem;
    logic        fits;

    // estimate low by at most one, then a single compare and subtract
    always_comb
    begin
        prod_next = num_reg * Magic;
        qd_next   = quo_reg * 32'(DivK);
        rem       = num_reg - qd_reg;
        fits      = (rem >= 32'(DivK));
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= DIV_STEPS;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[31];
            num_reg <= req.dividend[31] ? (~req.dividend + 32'd1) : req.dividend;
        end
        else
        begin
            case (cnt_reg)
                StepMul: quo_reg <= prod_next[62:31];
                StepEst: qd_reg  <= qd_next;
                StepFix: quo_reg <= quo_reg + 32'(fits);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rsp.busy     = (cnt_reg != '0);
        rsp.done     = (cnt_reg == DIV_CNT_W'(1));
        rsp.quotient = neg_reg ? (~quo_reg + 32'd1) : quo_reg;
    end

endmodule

/* rtl/core/tfcm_front.sv */
// front end: accepts requests, holds configuration, statistic and reference,
// computes the clamped level; depends on tfcm_pkg
module tfcm_front #(
    parameter int WIDTH  = tfcm_pkg::DEF_WIDTH,
    parameter int HEIGHT = tfcm_pkg::DEF_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       frame_end,
    input  logic [3:0]                 packet_id_nibble,
    input  logic [tfcm_pkg::LINE_W-1:0] line_number,
    input  logic [tfcm_pkg::COL_W-1:0] column,
    input  logic signed [tfcm_pkg::PIX_W-1:0] pixel,
    input  logic                       cfg_valid,
    input  logic [1:0]                 cfg_index,
    input  logic [7:0]                 cfg_data,
    output tfcm_pkg::cfg_t             cfg,
    output logic                       push,
    output tfcm_pkg::entry_t           push_data,
    input  logic                       full,
    output tfcm_pkg::div_req_t         div_req,
    input  tfcm_pkg::div_rsp_t         div_rsp
);
    import tfcm_pkg::*;

    ref_mode_t          mode_reg;
    logic               colour_reg;
    logic               fixed_reg;
    logic [CHAN_W-1:0]  alpha_reg;
    logic signed [31:0] ref_reg;
    logic signed [31:0] ref_next;
    logic signed [31:0] stat_reg;
    logic signed [31:0] stat_next;

    logic               accept;
    logic               fe_accept;
    logic               in_range;
    logic               pix_ok;
    logic signed [34:0] p_ext;
    logic signed [34:0] r_ext;
    logic signed [17:0] fx;
    logic signed [17:0] fx_adj;
    logic signed [17:0] fx_q;
    logic signed [34:0] t;
    logic signed [34:0] hi;
    logic [LEVEL_W-1:0] level;

    function automatic logic signed [31:0] start_value(input ref_mode_t m);
        return (m == MODE_MIN) ? 32'(STAT_MIN_START) : 32'sd0;
    endfunction

    // handshake and classification
    always_comb
    begin
        item_stall = full || div_rsp.busy;
        accept     = item_valid && !item_stall;
        in_range   = ({26'd0, line_number} < 32'(HEIGHT)) && ({25'd0, column} < 32'(WIDTH));
        pix_ok     = !frame_end && (packet_id_nibble != DISCARD_NIBBLE) && in_range;
        push       = accept && pix_ok;
        fe_accept  = accept && frame_end;
    end

    // offset against the reference
    always_comb
    begin
        p_ext  = 35'(pixel);
        r_ext  = 35'(ref_reg);
        fx     = 18'(pixel) - 18'(FIXED_BASE);
        fx_adj = fx[17] ? (fx + 18'sd3) : fx;
        fx_q   = fx_adj >>> 2;
        case (mode_reg)
            MODE_MEAN:
            begin
                if (colour_reg && fixed_reg)
                begin
                    t = 35'(fx_q) + 35'(MEAN_BIAS);
                end
                else
                begin
                    t = p_ext - r_ext + 35'(MEAN_BIAS);
                end
            end
            MODE_MIN: t = p_ext - r_ext;
            MODE_MAX: t = (colour_reg ? 35'(COLOUR_SPAN) : 35'(GREY_MAX)) - r_ext + p_ext;
            default:  t = p_ext;
        endcase
    end

    // clamp to the output range
    always_comb
    begin
        hi = colour_reg ? 35'(COLOUR_MAX) : 35'(GREY_MAX);
        if (t < 35'sd0)
        begin
            level = '0;
        end
        else if (t > hi)
        begin
            level = hi[LEVEL_W-1:0];
        end
        else
        begin
            level = t[LEVEL_W-1:0];
        end
        push_data.level = level;
        push_data.line  = line_number;
        push_data.col   = column;
    end

    // running frame statistic
    always_comb
    begin
        stat_next = stat_reg;
        if (cfg_valid && (cfg_index == REG_MODE))
        begin
            stat_next = start_value(ref_mode_t'(cfg_data[1:0]));
        end
        else if (fe_accept)
        begin
            stat_next = start_value(mode_reg);
        end
        else if (push)
        begin
            case (mode_reg)
                MODE_MEAN: stat_next = stat_reg + 32'(pixel);
                MODE_MIN:  stat_next = (stat_reg > 32'(pixel)) ? 32'(pixel) : stat_reg;
                MODE_MAX:  stat_next = (stat_reg < 32'(pixel)) ? 32'(pixel) : stat_reg;
                default:   stat_next = stat_reg;
            endcase
        end
    end

    // reference commit at frame end, mean mode waits for the divider
    always_comb
    begin
        ref_next = ref_reg;
        if (fe_accept && (mode_reg != MODE_MEAN))
        begin
            ref_next = stat_reg;
        end
        else if (div_rsp.done)
        begin
            ref_next = signed'(div_rsp.quotient);
        end
        div_req.start    = fe_accept && (mode_reg == MODE_MEAN);
        div_req.dividend = stat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MEAN;
            colour_reg <= 1'b1;
            fixed_reg  <= 1'b0;
            alpha_reg  <= 8'hFF;
            ref_reg    <= '0;
            stat_reg   <= '0;
        end
        else
        begin
            ref_reg  <= ref_next;
            stat_reg <= stat_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= ref_mode_t'(cfg_data[1:0]);
                    REG_COLOUR: colour_reg <= cfg_data[0];
                    REG_FIXED:  fixed_reg  <= cfg_data[0];
                    REG_ALPHA:  alpha_reg  <= cfg_data;
                    default:    alpha_reg  <= alpha_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.colour = colour_reg;
        cfg.alpha  = alpha_reg;
    end

    // a mean-mode frame end always starts the divider
    assert property (@(posedge clk) disable iff (!rst_n)
        (fe_accept && (mode_reg == MODE_MEAN)) |=> div_rsp.busy)
        else $error("divider not started at frame end");

    // no pixel enters while the reference is being computed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && div_rsp.busy))
        else $error("pixel accepted while reference pending");

    // the reference only moves on a frame end or a divider result
    assert property (@(posedge clk) disable iff (!rst_n)
        (!fe_accept && !div_rsp.done) |=> $stable(ref_reg))
        else $error("reference changed outside frame end");

endmodule

/* rtl/core/tfcm_queue.sv */
// short request queue between front and back end
// depends on tfcm_pkg
module tfcm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tfcm_pkg::entry_t push_data,
    input  logic             pop,
    output tfcm_pkg::entry_t pop_data,
    output logic             full,
    output logic             empty
);
    import tfcm_pkg::*;

    entry_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_comb
    begin
        pop_data = mem[rd_ptr_reg];
        full     = (count_reg == Q_CNT_W'(Q_DEPTH));
        empty    = (count_reg == '0);
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overrun or underrun");

endmodule

/* rtl/core/tfcm_back.sv */
// back end: mirrored index, grey or color ramp, output register
// depends on tfcm_pkg
module tfcm_back #(
    parameter int WIDTH = tfcm_pkg::DEF_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tfcm_pkg::cfg_t              cfg,
    input  logic                        empty,
    input  tfcm_pkg::entry_t            pop_data,
    output logic                        pop,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [tfcm_pkg::IDX_W-1:0]  pixel_index,
    output logic [tfcm_pkg::CHAN_W-1:0] red,
    output logic [tfcm_pkg::CHAN_W-1:0] green,
    output logic [tfcm_pkg::CHAN_W-1:0] blue,
    output logic [tfcm_pkg::CHAN_W-1:0] alpha
);
    import tfcm_pkg::*;

    logic              valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [CHAN_W-1:0] alpha_reg;

    logic [IDX_W-1:0]  idx_next;
    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] lo;

    // take a request when the output register is free or draining
    always_comb
    begin
        pop = !empty && (!valid_reg || !result_stall);
    end

    // mirrored target index
    always_comb
    begin
        idx_next = IDX_W'(32'(pop_data.line) * 32'(WIDTH) + 32'(WIDTH - 1)
                          - 32'(pop_data.col));
    end

    // grey level or five-band ramp
    always_comb
    begin
        lo = pop_data.level[CHAN_W-1:0];
        if (cfg.colour)
        begin
            case (pop_data.level[10:8])
                BAND_BLUE:
                begin
                    red_next = 8'd0;  green_next = 8'd0;  blue_next = lo;
                end
                BAND_CYAN:
                begin
                    red_next = 8'd0;  green_next = lo;    blue_next = 8'd255;
                end
                BAND_GREEN:
                begin
                    red_next = 8'd0;  green_next = 8'd255; blue_next = ~lo;
                end
                BAND_YELLOW:
                begin
                    red_next = lo;    green_next = 8'd255; blue_next = 8'd0;
                end
                default:
                begin
                    red_next = 8'd255; green_next = ~lo;   blue_next = 8'd0;
                end
            endcase
        end
        else
        begin
            red_next   = lo;
            green_next = lo;
            blue_next  = lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            idx_reg   <= idx_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= cfg.alpha;
        end
    end

    always_comb
    begin
        result_valid = valid_reg;
        pixel_index  = idx_reg;
        red          = red_reg;
        green        = green_reg;
        blue         = blue_reg;
        alpha        = alpha_reg;
    end

endmodule

/* rtl/core/thermal_false_color_mapper.sv */
// top level of the thermal false-color mapper
// depends on tfcm_pkg, tfcm_front, tfcm_div, tfcm_queue, tfcm_back
//
// Usage:
//   Item channel (item_valid / item_stall) carries one request per cycle while item_stall is low: a
//   pixel with packet nibble, line and column, or a frame-end marker. Discard
//   packets and out-of-range positions give no result; frame ends give none.
//   Result channel (result_valid / result_stall) returns the mirrored index
//   and the RGBA color of each kept pixel, in order.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while the block is idle.
//   Throughput is one pixel per cycle while neither stall is raised. An accepted
//   pixel passes through the queue and then the output register to result_valid.
//   A frame end in mean mode runs a reciprocal-multiply divide by WIDTH*HEIGHT;
//   item_stall stays high while the divider is busy. Other frame ends pass without a stall.
//   When result_stall is high the output register holds; the four-entry
//   queue keeps accepting until it fills, then item_stall rises.
//   Reset clears the configuration to mean mode, color output, alpha 255,
//   reference and statistic zero, and empties the queue.
module thermal_false_color_mapper #(
    parameter int WIDTH  = tfcm_pkg::DEF_WIDTH,
    parameter int HEIGHT = tfcm_pkg::DEF_HEIGHT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               frame_end,
    input  logic [3:0]                         packet_id_nibble,
    input  logic [tfcm_pkg::LINE_W-1:0]        line_number,
    input  logic [tfcm_pkg::COL_W-1:0]         column,
    input  logic signed [tfcm_pkg::PIX_W-1:0]  pixel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [tfcm_pkg::IDX_W-1:0]         pixel_index,
    output logic [tfcm_pkg::CHAN_W-1:0]        red,
    output logic [tfcm_pkg::CHAN_W-1:0]        green,
    output logic [tfcm_pkg::CHAN_W-1:0]        blue,
    output logic [tfcm_pkg::CHAN_W-1:0]        alpha,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [7:0]                         cfg_data
);
    import tfcm_pkg::*;

    localparam int Divisor = WIDTH * HEIGHT;

    cfg_t     cfg;
    entry_t   push_data;
    entry_t   pop_data;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    tfcm_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .frame_end        (frame_end),
        .packet_id_nibble (packet_id_nibble),
        .line_number      (line_number),
        .column           (column),
        .pixel            (pixel),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cfg              (cfg),
        .push             (push),
        .push_data        (push_data),
        .full             (full),
        .div_req          (div_req),
        .div_rsp          (div_rsp)
    );

    tfcm_div #(
        .DIVISOR (Divisor)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tfcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    tfcm_back #(
        .WIDTH (WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_index  (pixel_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha)
    );

endmodule

/* sim/thermal_false_color_mapper_test.sv */
// self-checking testbench for thermal_false_color_mapper, with its own mapping predictor
// depends on tfcm_pkg and the rtl/core sources; bursty sender, stalling receiver
`timescale 1ns / 100ps

module thermal_false_color_mapper_test;
    import tfcm_pkg::*;

    localparam int IMG_W         = DEF_WIDTH;
    localparam int IMG_H         = DEF_HEIGHT;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 32;
    localparam int PRINT_CAP     = 100;

    // one pixel request or frame-end marker
    typedef struct packed {
        logic        frame_end;
        logic [3:0]  nibble;
        logic [5:0]  line;
        logic [6:0]  col;
        logic [15:0] pix;
    } pix_req_t;

    // one mapped output pixel
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] a;
    } mapped_px_t;

    logic clk;
    logic rst_n = 1'b0;

    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        frame_end;
    logic [3:0]  packet_id_nibble;
    logic [5:0]  line_number;
    logic [6:0]  column;
    logic signed [15:0] pixel;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data = 8'd0;

    pix_req_t offered = '0;

    assign frame_end        = offered.frame_end;
    assign packet_id_nibble = offered.nibble;
    assign line_number      = offered.line;
    assign column           = offered.col;
    assign pixel            = offered.pix;

    // predictor copy of settings and frame state
    ref_mode_t   mode_now;
    logic        colour_now;
    logic        fixed_now;
    logic [7:0]  alpha_now;
    logic [31:0] ref_level;
    logic [31:0] frame_stat;

    pix_req_t   pixel_requests[$];
    mapped_px_t mapped_due[$];
    int         mismatch_count = 0;
    int         hold_requests = 0;

    thermal_false_color_mapper uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid),
        .item_stall       (item_stall),
        .frame_end        (frame_end),
        .packet_id_nibble (packet_id_nibble),
        .line_number      (line_number),
        .column           (column),
        .pixel            (pixel),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .pixel_index      (pixel_index),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .alpha            (alpha),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] stat_start(input ref_mode_t m);
        return (m == MODE_MIN) ? 32'(STAT_MIN_START) : 32'd0;
    endfunction

    function automatic longint clamp_level(input longint v, input longint hi);
        if (v > hi)
            return hi;
        if (v < 0)
            return 0;
        return v;
    endfunction

    // register write as seen by the block
    function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] data);
        case (idx)
            REG_MODE:
            begin
                mode_now   = ref_mode_t'(data[1:0]);
                frame_stat = stat_start(mode_now);
            end
            REG_COLOUR: colour_now = data[0];
            REG_FIXED:  fixed_now  = data[0];
            REG_ALPHA:  alpha_now  = data;
            default: ;
        endcase
    endfunction

    // statistic update or reference commit, offset, clamp and color mapping of one accepted request
    function automatic void predict_request(input pix_req_t rq);
        longint     p;
        longint     r;
        longint     s;
        longint     t;
        longint     v;
        logic [7:0] lo;
        mapped_px_t m;
        p = longint'($signed(rq.pix));
        r = longint'($signed(ref_level));
        s = longint'($signed(frame_stat));
        // frame end commits the reference and restarts the statistic
        if (rq.frame_end)
        begin
            if (mode_now == MODE_MEAN)
            begin
                s = s / longint'(IMG_W * IMG_H);
                ref_level = s[31:0];
            end
            else
                ref_level = frame_stat;
            frame_stat = stat_start(mode_now);
            return;
        end
        // discard packets and off-image positions are dropped
        if (rq.nibble == DISCARD_NIBBLE || rq.line >= IMG_H || rq.col >= IMG_W)
            return;
        case (mode_now)
            MODE_MEAN:
            begin
                frame_stat = frame_stat + p[31:0];
                if (colour_now && fixed_now)
                    t = (p - FIXED_BASE) / 4 + MEAN_BIAS;
                else
                    t = p - r + MEAN_BIAS;
            end
            MODE_MIN:
            begin
                if (s > p)
                    frame_stat = p[31:0];
                t = p - r;
            end
            MODE_MAX:
            begin
                if (s < p)
                    frame_stat = p[31:0];
                t = (colour_now ? longint'(COLOUR_SPAN) : longint'(GREY_MAX)) - (r - p);
            end
            default: t = p;
        endcase
        // grey level or five-band ramp
        if (colour_now)
        begin
            v  = clamp_level(t, COLOUR_MAX);
            lo = v[7:0];
            if (v < 256)
            begin
                m.r = 8'd0;  m.g = 8'd0;  m.b = lo;
            end
            else if (v < 512)
            begin
                m.r = 8'd0;  m.g = lo;  m.b = 8'd255;
            end
            else if (v < 768)
            begin
                m.r = 8'd0;  m.g = 8'd255;  m.b = 8'd255 - lo;
            end
            else if (v < 1024)
            begin
                m.r = lo;  m.g = 8'd255;  m.b = 8'd0;
            end
            else
            begin
                m.r = 8'd255;  m.g = 8'd255 - lo;  m.b = 8'd0;
            end
        end
        else
        begin
            v   = clamp_level(t, GREY_MAX);
            m.r = v[7:0];
            m.g = v[7:0];
            m.b = v[7:0];
        end
        v     = longint'(rq.line) * IMG_W + (IMG_W - 1 - longint'(rq.col));
        m.idx = v[IDX_W-1:0];
        m.a   = alpha_now;
        mapped_due.push_back(m);
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // driver: bursts of requests from the pending queue with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            offered    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                predict_request(offered);
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pixel_requests.size() > 0)
                begin
                    offered    <= pixel_requests.pop_front();
                    item_valid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 48);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24)
                                                               : $urandom_range(0, 3);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor: check results in order, stall on a changing pattern or a long hold
    int hold_left;
    int hold_served;
    int stall_pct;
    int stall_span;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left   = 0;
            hold_served = 0;
            stall_pct   = 0;
            stall_span  = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (mapped_due.size() == 0)
                    flag_mismatch("result with no request pending, index", pixel_index, 0);
                else
                begin
                    mapped_px_t want;
                    want = mapped_due.pop_front();
                    if (pixel_index !== want.idx)
                        flag_mismatch("pixel_index", pixel_index, want.idx);
                    if (red !== want.r)
                        flag_mismatch("red", red, want.r);
                    if (green !== want.g)
                        flag_mismatch("green", green, want.g);
                    if (blue !== want.b)
                        flag_mismatch("blue", blue, want.b);
                    if (alpha !== want.a)
                        flag_mismatch("alpha", alpha, want.a);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
                result_stall <= 1'b1;
            end
            else
            begin
                if (stall_span == 0)
                begin
                    stall_span = $urandom_range(20, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        2: stall_pct = 40;
                        default: stall_pct = 75;
                    endcase
                end
                stall_span--;
                result_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("thermal_false_color_mapper_test: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // write all four registers, with random junk above the used bits
    task automatic set_config(input ref_mode_t m, input logic colour, input logic fixed,
                              input logic [7:0] a);
        logic [7:0] data;
        data = 8'($urandom);
        data[1:0] = m;
        write_reg(REG_MODE, data);
        data = 8'($urandom);
        data[0] = colour;
        write_reg(REG_COLOUR, data);
        data = 8'($urandom);
        data[0] = fixed;
        write_reg(REG_FIXED, data);
        write_reg(REG_ALPHA, a);
    endtask

    task automatic wait_idle(input int settle);
        @(negedge clk);
        while (pixel_requests.size() != 0 || item_valid || mapped_due.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic queue_pixel(input logic [3:0] nib, input logic [5:0] ln,
                               input logic [6:0] col, input logic [15:0] pix);
        pix_req_t rq;
        rq.frame_end = 1'b0;
        rq.nibble    = nib;
        rq.line      = ln;
        rq.col       = col;
        rq.pix       = pix;
        pixel_requests.push_back(rq);
    endtask

    // frame end with random don't-care fields
    task automatic queue_frame_end();
        pix_req_t rq;
        rq = pix_req_t'({$urandom, $urandom});
        rq.frame_end = 1'b1;
        pixel_requests.push_back(rq);
    endtask

    function automatic logic [15:0] pick_pixel();
        longint x;
        case ($urandom_range(0, 9))
            0, 1, 2: x = longint'($signed(16'($urandom)));
            3:
            begin
                case ($urandom_range(0, 3))
                    0: x = -32768;
                    1: x = 32767;
                    2: x = 0;
                    default: x = -1;
                endcase
            end
            4, 5: x = $urandom_range(3000, 9500);
            // near the current reference, from 1500 below it to 500 above it
            default: x = longint'($signed(ref_level)) + longint'($urandom_range(0, 2000)) - 1500;
        endcase
        if (x > 32767)
            x = 32767;
        if (x < -32768)
            x = -32768;
        return x[15:0];
    endfunction

    // one frame of random pixels, mostly well-formed, then its frame end
    task automatic queue_frame(inout int counted);
        int         n;
        logic [3:0] nib;
        logic [5:0] ln;
        logic [6:0] col;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
        begin
            nib = ($urandom_range(0, 11) == 0) ? DISCARD_NIBBLE : 4'($urandom_range(0, 14));
            ln  = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(60, 63))
                                               : 6'($urandom_range(0, 59));
            col = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(80, 127))
                                               : 7'($urandom_range(0, 79));
            queue_pixel(nib, ln, col, pick_pixel());
            counted++;
        end
        queue_frame_end();
        counted++;
    endtask

    task automatic phase_config(input int ph);
        case (ph)
            1: set_config(MODE_MEAN, 1'b1, 1'b1, 8'd0);
            2: set_config(MODE_MIN,  1'b1, 1'b0, 8'd128);
            3: set_config(MODE_MAX,  1'b1, 1'b0, 8'd255);
            4: set_config(MODE_MEAN, 1'b0, 1'b0, 8'd17);
            5: set_config(MODE_MIN,  1'b0, 1'b1, 8'd200);
            6: set_config(MODE_MAX,  1'b0, 1'b1, 8'd0);
            7: set_config(MODE_RAW,  1'b1, 1'b0, 8'd90);
            8: set_config(MODE_RAW,  1'b0, 1'b1, 8'd255);
            9: set_config(MODE_MEAN, 1'b1, 1'b1, 8'd255);
            default: set_config(ref_mode_t'($urandom_range(0, 3)), 1'($urandom),
                                1'($urandom), 8'($urandom));
        endcase
    endtask

    // band edges of the ramp with a zero reference and a bias of 128
    int ramp_pix [12] = '{-129, -128, 127, 128, 383, 384, 639, 640, 895, 896, 1151, 1152};

    initial
    begin
        int counted;
        mode_now   = MODE_MEAN;
        colour_now = 1'b1;
        fixed_now  = 1'b0;
        alpha_now  = 8'd255;
        ref_level  = 32'd0;
        frame_stat = stat_start(MODE_MEAN);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests in the reset configuration
        queue_pixel(4'd0, 6'd0, 7'd0, 16'h8000);
        queue_pixel(4'd14, 6'd59, 7'd79, 16'h7FFF);
        queue_pixel(DISCARD_NIBBLE, 6'd10, 7'd10, 16'h0000);
        queue_pixel(4'd1, 6'd60, 7'd0, 16'd100);
        queue_pixel(4'd2, 6'd0, 7'd80, 16'd100);
        queue_pixel(4'd7, 6'd63, 7'd127, 16'd100);
        for (int i = 0; i < 12; i++)
            queue_pixel(4'(i), 6'(i * 5), 7'(i * 7), 16'(ramp_pix[i]));
        queue_frame_end();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle(SETTLE_CYCLES);
            if (ph > 0)
                phase_config(ph);
            @(negedge clk);
            // receiver holds off long enough for the block to fill and stall
            if (ph == 3)
                hold_requests++;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                queue_frame(counted);
                // sender goes quiet until every result is back
                if (ph == 5 && counted >= PHASE_ITEMS / 2 && counted < PHASE_ITEMS)
                    wait_idle(0);
            end
        end

        wait_idle(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("thermal_false_color_mapper_test: PASS");
        else
            $display("thermal_false_color_mapper_test: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/tfcm_pkg.sv
rtl/core/tfcm_div.sv
rtl/core/tfcm_front.sv
rtl/core/tfcm_queue.sv
rtl/core/tfcm_back.sv
rtl/core/thermal_false_color_mapper.sv
sim/thermal_false_color_mapper_test.sv
